### src/lbm_pkg.sv
// shared types, constants and helpers of the label boundary marker
`timescale 1ns / 1ps
`default_nettype none

package lbm_pkg;

   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_WIDTH  = 4096;
   localparam int LABEL_BITS = 32;

   // configuration values and output coordinates have fixed widths
   localparam int CFG_BITS       = 13;
   localparam int COORD_BITS     = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int ROW_ADDR_BITS  = $clog2(MAX_HEIGHT);

   localparam logic [CFG_BITS-1:0] MAX_HEIGHT_CFG = CFG_BITS'(MAX_HEIGHT);
   localparam logic [CFG_BITS-1:0] MAX_WIDTH_CFG  = CFG_BITS'(MAX_WIDTH);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_HEIGHT = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1
   } csr_index_type;

   // where a pixel sits in the image, captured when the item is taken
   typedef struct packed {
      logic col_nz;
      logic row_nz;
      logic last_row;
      logic last_col;
   } pos_flags_type;

   // result slots of one item, in output order
   localparam int SLOT_DIAG   = 0;   // pixel (c-1, r-1)
   localparam int SLOT_LEFT   = 1;   // pixel (c-1, r) on the last row
   localparam int SLOT_ABOVE  = 2;   // pixel (c, r-1) in the last column
   localparam int SLOT_CORNER = 3;   // bottom-right corner
   localparam int NUM_SLOTS   = 4;

   function automatic logic [CFG_BITS-1:0] clamp_cfg(
      input logic [CFG_BITS-1:0] value,
      input logic [CFG_BITS-1:0] max_value
   );
      logic [CFG_BITS-1:0] result;
      if (value == '0) result = CFG_BITS'(1);
      else if (value > max_value) result = max_value;
      else result = value;
      return result;
   endfunction

   function automatic logic lab_pos(input logic [LABEL_BITS-1:0] value);
      return (value != '0) && !value[LABEL_BITS-1];
   endfunction

endpackage

`default_nettype wire

### src/lbm_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### src/label_boundary_marker.sv
// top level of the label boundary marker
`timescale 1ns / 1ps
`default_nettype none

// label_boundary_marker takes one segment label per item in column-major
// order (image_height labels of a column, row 0 first, then the next column)
// and returns one boundary bit per pixel, tagged with its column and row, as
// soon as the pixel's down, right and diagonal neighbours have come in. An
// input item can be taken every cycle while the result port keeps up. Each
// item gives 0 to 4 results and the result port moves one result per cycle
// when the receiver does not stall. An item with two results (a last-row
// pixel past column 0 and row 0, or a last-column pixel past row 0 and
// column 0) holds the input until only its last result is pending, and so
// does the bottom-right corner item with up to four. The result serializer
// is the limit, and receiver stalls add to it. Once an item is in the input
// register and the result register is free, the line store read data and
// the input register feed the boundary logic and load the result register,
// which offers the first result. The line store keeps the previous column,
// one 32-bit label per row (4096 rows), with one write and one read port. It
// needs no clearing pass since an entry is only used after the current image
// has written it. Writing either register restarts the image at column 0,
// row 0; writes to other indexes are ignored. Write registers only while the
// block is idle. A value of 0 is taken as 1 and a value above 4096 as 4096.

module label_boundary_marker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 csr_we,
   input  wire logic [lbm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [lbm_pkg::CFG_BITS-1:0]         csr_wdata,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [lbm_pkg::LABEL_BITS-1:0] req_label,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [lbm_pkg::COORD_BITS-1:0]       rsp_out_col,
   output logic      [lbm_pkg::COORD_BITS-1:0]       rsp_out_row,
   output logic                                      rsp_boundary,
   output logic                                      rsp_run_last
);

   // configuration
   logic [lbm_pkg::CFG_BITS-1:0] height_ff, height_in;
   logic [lbm_pkg::CFG_BITS-1:0] width_ff, width_in;

   // position of the next pixel to arrive
   logic [lbm_pkg::ROW_ADDR_BITS-1:0] row_ff, row_in;
   logic [lbm_pkg::COORD_BITS-1:0]    col_ff, col_in;

   // neighbours of the pixel in the input register
   logic [lbm_pkg::LABEL_BITS-1:0] diag_ff, diag_in;
   logic [lbm_pkg::LABEL_BITS-1:0] above_ff, above_in;

   // input register (stage 1)
   logic                              s1_valid_ff, s1_valid_in;
   logic [lbm_pkg::LABEL_BITS-1:0]    s1_label_ff;
   logic [lbm_pkg::ROW_ADDR_BITS-1:0] s1_row_ff;
   logic [lbm_pkg::COORD_BITS-1:0]    s1_col_ff;
   lbm_pkg::pos_flags_type            s1_flags_ff;

   // result register (stage 2): pending slots and their boundary bits
   logic [lbm_pkg::NUM_SLOTS-1:0]  s2_mask_ff, s2_mask_in;
   logic [lbm_pkg::NUM_SLOTS-1:0]  s2_bnd_ff;
   logic [lbm_pkg::COORD_BITS-1:0] s2_row_ff;
   logic [lbm_pkg::COORD_BITS-1:0] s2_col_ff;

   logic                           req_take;
   logic                           rsp_take;
   logic                           s2_free;
   logic                           s1_move;
   logic                           csr_known;
   lbm_pkg::pos_flags_type         in_flags;
   logic [lbm_pkg::LABEL_BITS-1:0] ram_rd_data;
   logic [lbm_pkg::LABEL_BITS-1:0] left_label;
   logic [lbm_pkg::NUM_SLOTS-1:0]  new_mask;
   logic [lbm_pkg::NUM_SLOTS-1:0]  new_bnd;
   logic [lbm_pkg::NUM_SLOTS-1:0]  sel;
   logic                           diag_bnd;

   // ---------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------

   // result register can take a new item when empty or on its last result
   assign rsp_valid = |s2_mask_ff;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign s2_free   = !rsp_valid || (rsp_take && $onehot(s2_mask_ff));
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take  = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // configuration registers and position counters
   // ---------------------------------------------------------------

   // only the two dimension registers exist, other indexes are ignored
   assign csr_known = (csr_index == lbm_pkg::CSR_IMAGE_HEIGHT)
                   || (csr_index == lbm_pkg::CSR_IMAGE_WIDTH);

   always_comb begin
      in_flags.col_nz   = (col_ff != '0);
      in_flags.row_nz   = (row_ff != '0);
      in_flags.last_row = (lbm_pkg::CFG_BITS'(row_ff) + lbm_pkg::CFG_BITS'(1)) == height_ff;
      in_flags.last_col = (lbm_pkg::CFG_BITS'(col_ff) + lbm_pkg::CFG_BITS'(1)) == width_ff;
   end

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (csr_we) begin
         unique case (lbm_pkg::csr_index_type'(csr_index))
            lbm_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = lbm_pkg::clamp_cfg(csr_wdata, lbm_pkg::MAX_HEIGHT_CFG);
            end
            lbm_pkg::CSR_IMAGE_WIDTH: begin
               width_in = lbm_pkg::clamp_cfg(csr_wdata, lbm_pkg::MAX_WIDTH_CFG);
            end
            default: begin
            end
         endcase
         // a write to a known register starts a new image
         if (csr_known) begin
            row_in = '0;
            col_in = '0;
         end
      end else if (req_take) begin
         if (in_flags.last_row) begin
            row_in = '0;
            col_in = in_flags.last_col ? '0 : col_ff + lbm_pkg::COORD_BITS'(1);
         end else begin
            row_in = row_ff + lbm_pkg::ROW_ADDR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= lbm_pkg::MAX_HEIGHT_CFG;
         width_ff  <= lbm_pkg::MAX_WIDTH_CFG;
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

   // ---------------------------------------------------------------
   // previous-column line store: written and read at the same row
   // as the item is taken, read data holds until the next take
   // ---------------------------------------------------------------

   lbm_ram #(
      .WIDTH (lbm_pkg::LABEL_BITS),
      .DEPTH (lbm_pkg::MAX_HEIGHT)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (row_ff),
      .wr_data (req_label),
      .rd_en   (req_take),
      .rd_addr (row_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_label_ff <= req_label;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         s1_flags_ff <= in_flags;
      end
   end

   // ---------------------------------------------------------------
   // boundary rules
   // ---------------------------------------------------------------

   // column 0 has no left column
   assign left_label = s1_flags_ff.col_nz ? ram_rd_data : '0;

   // interior pixel (c-1, r-1): down = left, right = above, diagonal = current
   always_comb begin
      if (diag_ff == '0) begin
         diag_bnd = 1'b1;
      end else if (!lbm_pkg::lab_pos(diag_ff)) begin
         diag_bnd = 1'b0;
      end else begin
         diag_bnd = (lbm_pkg::lab_pos(left_label) && left_label != diag_ff)
                 || (lbm_pkg::lab_pos(above_ff) && above_ff != diag_ff)
                 || (lbm_pkg::lab_pos(s1_label_ff) && s1_label_ff != diag_ff);
      end
   end

   always_comb begin
      new_mask[lbm_pkg::SLOT_DIAG]   = s1_flags_ff.col_nz && s1_flags_ff.row_nz;
      new_mask[lbm_pkg::SLOT_LEFT]   = s1_flags_ff.col_nz && s1_flags_ff.last_row;
      new_mask[lbm_pkg::SLOT_ABOVE]  = s1_flags_ff.last_col && s1_flags_ff.row_nz;
      new_mask[lbm_pkg::SLOT_CORNER] = s1_flags_ff.last_col && s1_flags_ff.last_row;

      new_bnd[lbm_pkg::SLOT_DIAG]   = diag_bnd;
      new_bnd[lbm_pkg::SLOT_LEFT]   = (left_label != s1_label_ff);
      new_bnd[lbm_pkg::SLOT_ABOVE]  = (above_ff != s1_label_ff);
      new_bnd[lbm_pkg::SLOT_CORNER] = 1'b0;
   end

   // neighbour registers follow the item leaving the input register
   always_comb begin
      diag_in  = diag_ff;
      above_in = above_ff;
      if (csr_we && csr_known) begin
         diag_in  = '0;
         above_in = '0;
      end else if (s1_move) begin
         // a new column starts with no upper neighbours
         diag_in  = s1_flags_ff.last_row ? '0 : left_label;
         above_in = s1_flags_ff.last_row ? '0 : s1_label_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_ff  <= '0;
         above_ff <= '0;
      end else begin
         diag_ff  <= diag_in;
         above_ff <= above_in;
      end
   end

   // ---------------------------------------------------------------
   // result register and serializer
   // ---------------------------------------------------------------

   // lowest pending slot goes out first
   assign sel = s2_mask_ff & (~s2_mask_ff + lbm_pkg::NUM_SLOTS'(1));

   always_comb begin
      s2_mask_in = s2_mask_ff;
      if (s1_move) begin
         s2_mask_in = new_mask;
      end else if (rsp_take) begin
         s2_mask_in = s2_mask_ff & ~sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
      end else begin
         s2_mask_ff <= s2_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_bnd_ff <= new_bnd;
         s2_row_ff <= lbm_pkg::COORD_BITS'(s1_row_ff);
         s2_col_ff <= s1_col_ff;
      end
   end

   assign rsp_out_col = s2_col_ff - lbm_pkg::COORD_BITS'(sel[lbm_pkg::SLOT_DIAG]
                                                        | sel[lbm_pkg::SLOT_LEFT]);
   assign rsp_out_row = s2_row_ff - lbm_pkg::COORD_BITS'(sel[lbm_pkg::SLOT_DIAG]
                                                        | sel[lbm_pkg::SLOT_ABOVE]);
   assign rsp_boundary = |(sel & s2_bnd_ff);
   assign rsp_run_last = (s2_mask_ff & ~sel) == '0;

endmodule

`default_nettype wire

### src/lbm_checker.sv
// port-level checks of the label boundary marker and their binding
`timescale 1ns / 1ps
`default_nettype none

module lbm_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic [lbm_pkg::COORD_BITS-1:0]        rsp_out_col,
   input wire logic [lbm_pkg::COORD_BITS-1:0]        rsp_out_row,
   input wire logic                                  rsp_boundary,
   input wire logic                                  rsp_run_last
);

   // no result is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_out_col) && $stable(rsp_out_row)
         && $stable(rsp_boundary) && $stable(rsp_run_last))
      else $error("stalled result changed");

   // results of one item leave back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("gap inside the results of one item");

   // results of one item never go back to a lower column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_out_col >= $past(rsp_out_col))
      else $error("results of one item out of column order");

   // the input only stalls behind results that cannot all leave this cycle
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && (rsp_stall || !rsp_run_last))
      else $error("input stalled with room for the item");

endmodule

bind label_boundary_marker lbm_checker u_lbm_checker (.*);

`default_nettype wire

### verif/label_boundary_marker_tb.sv
// self-checking testbench of the label boundary marker
`timescale 1ns / 1ps

// The block under test takes one segment label per item, column by column,
// and returns one boundary mark per pixel once the pixel's down, right and
// diagonal neighbours are in. This bench keeps its own scan position, its
// own copy of the previous column and its own dimension registers. For each
// label that the block accepts, it works out the marks that the label
// releases and queues them. Every mark that leaves the block is compared
// field by field with the oldest queued mark.
//
// Flow: reset, then a directed table (the reset dimensions, a 1x1 image from
// written zeros, a single-row image, writes to unused register indexes, a
// small 3x3 image), then random phases at various image sizes. The phases
// include the largest height and width, from written values above the limit.
// The idle patterns change between groups of phases, and the receiver
// holds off once for a long stretch.

module label_boundary_marker_tb;

   // the two unused register indexes must be ignored by the block
   localparam logic [lbm_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [lbm_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   localparam int SETTLE_CYCLES = 6;      // block latency plus margin
   localparam int STALL_LIMIT   = 2000;   // cycles without any handshake
   localparam int HOLD_AFTER    = 45;     // marks seen before the long hold
   localparam int HOLD_CYCLES   = 300;

   // one boundary mark as it leaves the block
   typedef struct packed {
      logic [lbm_pkg::COORD_BITS-1:0] col;
      logic [lbm_pkg::COORD_BITS-1:0] row;
      logic                           boundary;
      logic                           run_last;
   } mark_type;

   localparam mark_type NO_MARK = '0;

   // one row of the directed table: a register write or a label
   typedef enum logic {STEP_WRITE, STEP_LABEL} step_kind_type;

   typedef struct {
      step_kind_type                      kind;
      logic [lbm_pkg::CSR_INDEX_BITS-1:0] index;
      logic [lbm_pkg::CFG_BITS-1:0]       value;
      logic [lbm_pkg::LABEL_BITS-1:0]     label;
      int                                 n_typed;   // -1: marks come from the predictor
      mark_type                           typed_a;
      mark_type                           typed_b;
   } step_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  csr_we = 1'b0;
   logic [lbm_pkg::CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [lbm_pkg::CFG_BITS-1:0]          csr_wdata = '0;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [lbm_pkg::LABEL_BITS-1:0] req_label = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [lbm_pkg::COORD_BITS-1:0]        rsp_out_col;
   logic [lbm_pkg::COORD_BITS-1:0]        rsp_out_row;
   logic                                  rsp_boundary;
   logic                                  rsp_run_last;

   label_boundary_marker dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_label    (req_label),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_col  (rsp_out_col),
      .rsp_out_row  (rsp_out_row),
      .rsp_boundary (rsp_boundary),
      .rsp_run_last (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: dimensions, scan position and neighbour labels
   int unsigned                    img_height;
   int unsigned                    img_width;
   int unsigned                    scan_row;
   int unsigned                    scan_col;
   logic [lbm_pkg::LABEL_BITS-1:0] column_store [lbm_pkg::MAX_HEIGHT];
   logic [lbm_pkg::LABEL_BITS-1:0] diag_lab;
   logic [lbm_pkg::LABEL_BITS-1:0] above_lab;

   mark_type step_marks[$];       // marks released by the latest label
   mark_type expected_marks[$];   // marks still owed by the block
   step_type directed_steps[$];

   int mismatches = 0;
   int marks_seen = 0;
   int req_idle_pct = 0;       // chance in percent that the sender idles a cycle
   int rsp_stall_pct = 0;      // chance in percent that the receiver stalls a cycle
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   function automatic mark_type mk(input int unsigned col, input int unsigned row,
                                   input logic boundary, input logic run_last);
      mark_type m;
      m.col      = lbm_pkg::COORD_BITS'(col);
      m.row      = lbm_pkg::COORD_BITS'(row);
      m.boundary = boundary;
      m.run_last = run_last;
      return m;
   endfunction

   function automatic logic positive_label(input logic [lbm_pkg::LABEL_BITS-1:0] v);
      return (v != '0) && !v[lbm_pkg::LABEL_BITS-1];
   endfunction

   // zero means one, anything past the limit means the limit
   function automatic int unsigned saturate_dim(input logic [lbm_pkg::CFG_BITS-1:0] value,
                                                input int unsigned max_value);
      int unsigned v;
      v = int'(value);
      if (v == 0) v = 1;
      else if (v > max_value) v = max_value;
      return v;
   endfunction

   // register write as the block sees it; both dimensions restart the image
   function automatic void apply_register(input logic [lbm_pkg::CSR_INDEX_BITS-1:0] index,
                                          input logic [lbm_pkg::CFG_BITS-1:0] value);
      if (index == lbm_pkg::CSR_IMAGE_HEIGHT)
         img_height = saturate_dim(value, lbm_pkg::MAX_HEIGHT);
      else if (index == lbm_pkg::CSR_IMAGE_WIDTH)
         img_width = saturate_dim(value, lbm_pkg::MAX_WIDTH);
      else return;
      scan_row  = 0;
      scan_col  = 0;
      diag_lab  = '0;
      above_lab = '0;
   endfunction

   // marks released by one label, in the order the block sends them
   function automatic void predict_marks(input logic [lbm_pkg::LABEL_BITS-1:0] cur);
      int unsigned                    r;
      int unsigned                    c;
      logic [lbm_pkg::LABEL_BITS-1:0] left;
      logic                           b;
      mark_type                       m;
      step_marks.delete();
      r = scan_row;
      c = scan_col;
      if (r >= img_height) r = 0;
      if (c >= img_width) c = 0;
      left = '0;
      if (c >= 1) left = column_store[r];

      // pixel up-left of the current one now has all its neighbours
      if (c >= 1 && r >= 1) begin
         if (diag_lab == '0) b = 1'b1;
         else if (!positive_label(diag_lab)) b = 1'b0;
         else b = (positive_label(left) && left != diag_lab) ||
                  (positive_label(above_lab) && above_lab != diag_lab) ||
                  (positive_label(cur) && cur != diag_lab);
         step_marks.push_back(mk(c - 1, r - 1, b, 1'b0));
      end
      // last row: compare with the right neighbour only
      if (c >= 1 && r == img_height - 1)
         step_marks.push_back(mk(c - 1, r, left != cur, 1'b0));
      // last column: compare with the pixel below only
      if (c == img_width - 1 && r >= 1)
         step_marks.push_back(mk(c, r - 1, above_lab != cur, 1'b0));
      // bottom-right corner is never a boundary
      if (c == img_width - 1 && r == img_height - 1)
         step_marks.push_back(mk(c, r, 1'b0, 1'b0));

      diag_lab        = left;
      above_lab       = cur;
      column_store[r] = cur;
      r++;
      if (r >= img_height) begin
         r = 0;
         c++;
         if (c >= img_width) c = 0;
         diag_lab  = '0;
         above_lab = '0;
      end
      scan_row = r;
      scan_col = c;

      if (step_marks.size() > 0) begin
         m = step_marks[step_marks.size() - 1];
         m.run_last = 1'b1;
         step_marks[step_marks.size() - 1] = m;
      end
   endfunction

   // labels biased toward a few small values so that neighbours often match
   function automatic logic [lbm_pkg::LABEL_BITS-1:0] pick_label();
      logic [lbm_pkg::LABEL_BITS-1:0] lab;
      case ($urandom_range(9))
         0: lab = '0;
         1, 2, 3, 4: lab = lbm_pkg::LABEL_BITS'($urandom_range(4, 1));
         5: lab = -lbm_pkg::LABEL_BITS'($urandom_range(2, 1));
         6: begin
            case ($urandom_range(2))
               0: lab = {1'b0, {(lbm_pkg::LABEL_BITS - 1){1'b1}}};
               1: lab = {1'b1, {(lbm_pkg::LABEL_BITS - 1){1'b0}}};
               default: lab = '1;
            endcase
         end
         default: lab = lbm_pkg::LABEL_BITS'($urandom());
      endcase
      return lab;
   endfunction

   function automatic void add_write(input logic [lbm_pkg::CSR_INDEX_BITS-1:0] index,
                                     input logic [lbm_pkg::CFG_BITS-1:0] value);
      step_type s;
      s.kind    = STEP_WRITE;
      s.index   = index;
      s.value   = value;
      s.label   = '0;
      s.n_typed = -1;
      s.typed_a = NO_MARK;
      s.typed_b = NO_MARK;
      directed_steps.push_back(s);
   endfunction

   function automatic void add_label(input logic [lbm_pkg::LABEL_BITS-1:0] label,
                                     input int n_typed, input mark_type typed_a,
                                     input mark_type typed_b);
      step_type s;
      s.kind    = STEP_LABEL;
      s.index   = '0;
      s.value   = '0;
      s.label   = label;
      s.n_typed = n_typed;
      s.typed_a = typed_a;
      s.typed_b = typed_b;
      directed_steps.push_back(s);
   endfunction

   // offer one label, wait for the handshake, then queue what it owes
   task automatic send_label(input logic [lbm_pkg::LABEL_BITS-1:0] label,
                             input int n_typed,
                             input mark_type typed_a, input mark_type typed_b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_label <= label;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_marks(label);
      if (n_typed < 0) begin
         foreach (step_marks[i]) expected_marks.push_back(step_marks[i]);
      end else begin
         if (n_typed >= 1) expected_marks.push_back(typed_a);
         if (n_typed >= 2) expected_marks.push_back(typed_b);
      end
   endtask

   // wait until the block owes nothing, then give it time to settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_marks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [lbm_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [lbm_pkg::CFG_BITS-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_register(index, value);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [lbm_pkg::CFG_BITS-1:0] height,
                            input logic [lbm_pkg::CFG_BITS-1:0] width, input int n_items);
      write_register(lbm_pkg::CSR_IMAGE_HEIGHT, height);
      write_register(lbm_pkg::CSR_IMAGE_WIDTH, width);
      repeat (n_items) send_label(pick_label(), -1, NO_MARK, NO_MARK);
   endtask

   task automatic report(input string field, input int unsigned want,
                         input int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   // result side: check each mark taken, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_marks.size() == 0) begin
            $display("%0t: unexpected mark, expected none, actual col %0d row %0d",
                     $time, rsp_out_col, rsp_out_row);
            mismatches++;
         end else begin
            if (rsp_out_col !== expected_marks[0].col)
               report("out_col", expected_marks[0].col, rsp_out_col);
            if (rsp_out_row !== expected_marks[0].row)
               report("out_row", expected_marks[0].row, rsp_out_row);
            if (rsp_boundary !== expected_marks[0].boundary)
               report("boundary", expected_marks[0].boundary, rsp_boundary);
            if (rsp_run_last !== expected_marks[0].run_last)
               report("run_last", expected_marks[0].run_last, rsp_run_last);
            void'(expected_marks.pop_front());
         end
         marks_seen++;
      end
      // one long hold-off lets the block fill up and stall the sender
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && marks_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // watchdog: any handshake on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("label_boundary_marker_tb: FAIL");
         $finish;
      end
   end

   initial begin
      // reset state: full-size image, empty column store
      img_height = saturate_dim(lbm_pkg::CFG_BITS'(4096), lbm_pkg::MAX_HEIGHT);
      img_width  = saturate_dim(lbm_pkg::CFG_BITS'(4096), lbm_pkg::MAX_WIDTH);
      scan_row   = 0;
      scan_col   = 0;
      diag_lab   = '0;
      above_lab  = '0;
      foreach (column_store[i]) column_store[i] = '0;

      // reset dimensions: the first column releases nothing
      add_label(32'd1, 0, NO_MARK, NO_MARK);
      add_label(32'h8000_0000, 0, NO_MARK, NO_MARK);
      // zero written to both registers gives a 1x1 image: a single 0 per label
      add_write(lbm_pkg::CSR_IMAGE_HEIGHT, '0);
      add_write(lbm_pkg::CSR_IMAGE_WIDTH, '0);
      add_label(32'd0, 1, mk(0, 0, 1'b0, 1'b1), NO_MARK);
      add_label(32'h7fff_ffff, 1, mk(0, 0, 1'b0, 1'b1), NO_MARK);
      add_label(32'h8000_0000, 1, mk(0, 0, 1'b0, 1'b1), NO_MARK);
      // single row, two columns: the last-row rule, then the corner
      add_write(lbm_pkg::CSR_IMAGE_WIDTH, 13'd2);
      add_label(32'd5, 0, NO_MARK, NO_MARK);
      add_label(32'd5, 2, mk(0, 0, 1'b0, 1'b0), mk(1, 0, 1'b0, 1'b1));
      add_label(32'hffff_ffff, 0, NO_MARK, NO_MARK);
      add_label(32'd7, 2, mk(0, 0, 1'b1, 1'b0), mk(1, 0, 1'b0, 1'b1));
      // unused indexes must not restart the image in the middle
      add_label(32'd3, 0, NO_MARK, NO_MARK);
      add_write(CSR_SPARE_A, 13'd3);
      add_write(CSR_SPARE_B, 13'h1fff);
      add_label(32'd3, 2, mk(0, 0, 1'b0, 1'b0), mk(1, 0, 1'b0, 1'b1));
      // 3x3 image with gaps, equal, differing and negative labels
      add_write(lbm_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      add_write(lbm_pkg::CSR_IMAGE_WIDTH, 13'd3);
      add_label(32'd5, -1, NO_MARK, NO_MARK);
      add_label(32'd5, -1, NO_MARK, NO_MARK);
      add_label(32'd0, -1, NO_MARK, NO_MARK);
      add_label(32'd5, -1, NO_MARK, NO_MARK);
      add_label(32'd9, -1, NO_MARK, NO_MARK);
      add_label(-32'sd3, -1, NO_MARK, NO_MARK);
      add_label(32'd9, -1, NO_MARK, NO_MARK);
      add_label(32'd9, -1, NO_MARK, NO_MARK);
      add_label(32'd2, -1, NO_MARK, NO_MARK);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender idles a little, receiver a lot
      req_idle_pct  = 15;
      rsp_stall_pct = 64;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE)
            write_register(directed_steps[i].index, directed_steps[i].value);
         else
            send_label(directed_steps[i].label, directed_steps[i].n_typed,
                       directed_steps[i].typed_a, directed_steps[i].typed_b);
      end

      run_phase(13'd3, 13'd4, 20);
      // tallest column (value past the limit saturates), one column wide;
      // the long receiver hold-off falls in here
      run_phase(13'h1fff, 13'd1, 30);
      run_phase(13'd1, 13'd5, 15);

      // the other way round
      req_idle_pct  = 64;
      rsp_stall_pct = 15;
      run_phase(13'd6, 13'd1, 15);
      // widest row: one pixel high, 4096 columns
      run_phase(13'd1, 13'd4097, 30);
      run_phase(13'd2, 13'd2, 12);

      // no idling at all
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_phase(lbm_pkg::CFG_BITS'($urandom_range(8, 1)),
                lbm_pkg::CFG_BITS'($urandom_range(8, 1)), 12);
      run_phase(13'd4, 13'd3, 12);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_marks.size() == 0)
         $display("label_boundary_marker_tb: PASS");
      else
         $display("label_boundary_marker_tb: FAIL");
      $finish;
   end

endmodule
